// ===== rtl/frb_pkg.sv =====
// Package for the frame ring buffer: sizes, widths, operation codes,
// register indexes and the configuration bundle. No dependencies.
`default_nettype none

package frb_pkg;

	localparam int MAX_FRAMES      = 64;
	localparam int MAX_FRAME_BYTES = 256;

	localparam int SLOT_W  = $clog2(MAX_FRAMES);
	localparam int POS_W   = $clog2(MAX_FRAME_BYTES);
	localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
	localparam int FB_W    = $clog2(MAX_FRAME_BYTES + 1);
	localparam int ADDR_W  = SLOT_W + POS_W;
	localparam int DEPTH   = MAX_FRAMES * MAX_FRAME_BYTES;
	localparam int BYTE_W  = 8;

	localparam int KIND_W  = 2;
	localparam int IDX_W   = 6;
	localparam int OFF_W   = 8;
	localparam int CAPR_W  = 7;
	localparam int FBR_W   = 9;

	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic {
		REG_CAPACITY    = 1'b0,
		REG_FRAME_BYTES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] capacity;
		logic [FB_W-1:0]  frame_bytes;
		logic             clear;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              hit;
		logic [CAPR_W-1:0] frames_stored;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/frb_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on frb_pkg.
`default_nettype none

interface frb_req_if
	import frb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] push_byte;
	logic [IDX_W-1:0]  frame_index;
	logic [OFF_W-1:0]  byte_offset;

	modport source (output valid, kind, push_byte, frame_index, byte_offset, input ready);
	modport sink   (input valid, kind, push_byte, frame_index, byte_offset, output ready);
endinterface

interface frb_rsp_if
	import frb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              hit;
	logic [CAPR_W-1:0] frames_stored;

	modport source (output valid, read_byte, hit, frames_stored, input ready);
	modport sink   (input valid, read_byte, hit, frames_stored, output ready);
endinterface

`default_nettype wire

// ===== rtl/frb_core.sv =====
// Frame store datapath: pointer registers, byte memory and result register.
// Depends on frb_pkg and the channel interfaces in frb_if.sv.
`default_nettype none

module frb_core
	import frb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	frb_req_if.sink    req,
	frb_rsp_if.source  rsp
);

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  wpos_q;

	logic              valid_s1;
	logic              hit_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [BYTE_W-1:0] rdata_s1;

	logic              out_valid_q;
	rsp_t              out_q;

	logic              advance;
	logic              accept;
	logic              push_ok;
	logic              commit;
	logic [FB_W-1:0]   wpos_inc;
	logic [CNT_W-1:0]  head_inc;
	logic [SLOT_W-1:0] head_next;
	logic              full;
	logic              rd_ok;
	logic [SLOT_W-1:0] oldest;
	logic [CNT_W-1:0]  slot_sum;
	logic [SLOT_W-1:0] slot;
	logic              mem_we;
	logic              mem_re;
	logic [SLOT_W-1:0] head_d;
	logic [CNT_W-1:0]  count_d;
	logic [POS_W-1:0]  wpos_d;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	always_comb begin
		push_ok   = (cfg.capacity != '0) && ({1'b0, head_q} < cfg.capacity)
			&& ({1'b0, wpos_q} < cfg.frame_bytes);
		wpos_inc  = {1'b0, wpos_q} + FB_W'(1);
		commit    = wpos_inc >= cfg.frame_bytes;
		head_inc  = {1'b0, head_q} + CNT_W'(1);
		head_next = (head_inc >= cfg.capacity) ? '0 : head_inc[SLOT_W-1:0];
		full      = (cfg.capacity != '0) && (count_q == cfg.capacity);
		rd_ok     = ({1'b0, req.frame_index} < count_q)
			&& ({1'b0, req.byte_offset} < cfg.frame_bytes)
			&& (cfg.capacity != '0)
			&& !(full && (wpos_q != '0) && (req.frame_index == '0));
		oldest    = full ? head_q : '0;
		slot_sum  = {1'b0, oldest} + {1'b0, req.frame_index};
		slot      = (slot_sum >= cfg.capacity) ? SLOT_W'(slot_sum - cfg.capacity)
			: slot_sum[SLOT_W-1:0];
	end

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		wpos_d  = wpos_q;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		if (accept) begin
			unique case (kind_t'(req.kind))
				KIND_PUSH: begin
					if (push_ok) begin
						mem_we = 1'b1;
						if (commit) begin
							wpos_d = '0;
							head_d = head_next;
							if (count_q < cfg.capacity) begin
								count_d = count_q + CNT_W'(1);
							end
						end else begin
							wpos_d = wpos_inc[POS_W-1:0];
						end
					end
				end
				KIND_READ: begin
					mem_re = rd_ok;
				end
				KIND_CLEAR: begin
					head_d  = '0;
					count_d = '0;
					wpos_d  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			wpos_q  <= '0;
		end else if (cfg.clear) begin
			head_q  <= '0;
			count_q <= '0;
			wpos_q  <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			wpos_q  <= wpos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[{head_q, wpos_q}] <= req.push_byte;
		end
		if (mem_re) begin
			rdata_s1 <= mem[{slot, req.byte_offset}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= mem_re;
			count_s1 <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.read_byte     <= hit_s1 ? rdata_s1 : '0;
			out_q.hit           <= hit_s1;
			out_q.frames_stored <= CAPR_W'(count_s1);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_byte     = out_q.read_byte;
	assign rsp.hit           = out_q.hit;
	assign rsp.frames_stored = out_q.frames_stored;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAMES))
		else $error("stored frame count above the store size");

	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wpos_q} < cfg.frame_bytes)
		else $error("write position outside the frame");

	a_hit_needs_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.hit |-> out_q.frames_stored != '0)
		else $error("hit reported with no stored frames");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(hit_s1) && $stable(rdata_s1))
		else $error("stalled stage lost its word");

endmodule

`default_nettype wire

// ===== rtl/frame_ring_buffer.sv =====
// Frame ring buffer top level: APB register block and frame store core.
// Request words pass through the s1 stage and then the output register to the result word.
// Throughput: one word per cycle while rsp.ready is high, set by the single store byte access per item.
// Reset: pointers clear, capacity reads 64 and frame size 256; store contents stay undefined.
// Depends on frb_pkg, frb_if.sv and frb_core.
`default_nettype none

module frame_ring_buffer
	import frb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready,
	frb_req_if.sink                req,
	frb_rsp_if.source              rsp
);

	logic [CAPR_W-1:0] capacity_q;
	logic [FBR_W-1:0]  frame_bytes_q;
	logic              wr_en;
	reg_idx_t          reg_sel;
	cfg_t              cfg;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= CAPR_W'(MAX_FRAMES);
			frame_bytes_q <= FBR_W'(MAX_FRAME_BYTES);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_CAPACITY:    capacity_q    <= pwdata[CAPR_W-1:0];
				REG_FRAME_BYTES: frame_bytes_q <= pwdata[FBR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CAPACITY:    prdata = APB_DW'(capacity_q);
			REG_FRAME_BYTES: prdata = APB_DW'(frame_bytes_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		cfg.capacity = ({1'b0, capacity_q} > (CAPR_W+1)'(MAX_FRAMES))
			? CNT_W'(MAX_FRAMES) : CNT_W'(capacity_q);
		if (frame_bytes_q == '0) begin
			cfg.frame_bytes = FB_W'(1);
		end else if ({1'b0, frame_bytes_q} > (FBR_W+1)'(MAX_FRAME_BYTES)) begin
			cfg.frame_bytes = FB_W'(MAX_FRAME_BYTES);
		end else begin
			cfg.frame_bytes = FB_W'(frame_bytes_q);
		end
		cfg.clear = wr_en;
	end

	frb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the frame ring buffer: drives request words and APB
// register writes, predicts every response word and compares it on arrival.
// Depends on frb_pkg, frb_if.sv and frame_ring_buffer.
`default_nettype none

module testbench;
	import frb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 100;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		int cap;
		int fb;
		int words;
		int push_pct;
	} setting_t;

	class frame_ring_shadow;
		bit [BYTE_W-1:0] bytes_held [DEPTH];
		int unsigned head;
		int unsigned count;
		int unsigned wpos;
		int unsigned cap_reg;
		int unsigned fb_reg;
		rsp_t replies [$];
		int errors;
		int checked;
		int hits;
		int commits;

		function new();
			cap_reg = MAX_FRAMES;
			fb_reg  = MAX_FRAME_BYTES;
			clear_pointers();
		endfunction

		function void clear_pointers();
			head  = 0;
			count = 0;
			wpos  = 0;
		endfunction

		function int unsigned eff_cap();
			return (cap_reg > MAX_FRAMES) ? MAX_FRAMES : cap_reg;
		endfunction

		function int unsigned eff_fb();
			if (fb_reg == 0)
				return 1;
			return (fb_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : fb_reg;
		endfunction

		function void set_reg(reg_idx_t r, logic [APB_DW-1:0] v);
			if (r == REG_CAPACITY)
				cap_reg = v & 32'h7F;
			else
				fb_reg = v & 32'h1FF;
			clear_pointers();
		endfunction

		function void take_word(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b,
				logic [IDX_W-1:0] i, logic [OFF_W-1:0] o);
			rsp_t r;
			int unsigned c;
			int unsigned f;
			int unsigned oldest;
			int unsigned slot;
			bit full;
			bit ok;
			c = eff_cap();
			f = eff_fb();
			r = '0;
			case (k)
				KIND_PUSH: begin
					if (c != 0 && head < c && wpos < f) begin
						bytes_held[head * MAX_FRAME_BYTES + wpos] = b;
						wpos++;
						if (wpos >= f) begin
							wpos = 0;
							head = (head + 1) % c;
							if (count < c)
								count++;
							commits++;
						end
					end
				end
				KIND_READ: begin
					full = (c != 0) && (count == c);
					ok = (i < count) && (o < f) && (c != 0);
					if (ok && full && wpos != 0 && i == 0)
						ok = 1'b0;
					if (ok) begin
						oldest = full ? head : 0;
						slot = (oldest + i) % c;
						r.read_byte = bytes_held[slot * MAX_FRAME_BYTES + o];
						r.hit = 1'b1;
						hits++;
					end
				end
				KIND_CLEAR: begin
					clear_pointers();
				end
				default: begin
				end
			endcase
			r.frames_stored = count[CAPR_W-1:0];
			replies.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("MISMATCH: %s", msg);
		endtask

		task check_word(rsp_t got);
			rsp_t want;
			checked++;
			if (replies.size() == 0) begin
				report($sformatf("response word %0d arrived with nothing pending", checked));
				return;
			end
			want = replies.pop_front();
			if (got.read_byte !== want.read_byte || got.hit !== want.hit
					|| got.frames_stored !== want.frames_stored)
				report($sformatf({"word %0d: read_byte %h/%h hit %b/%b ",
					"frames_stored %0d/%0d (got/want)"}, checked, got.read_byte,
					want.read_byte, got.hit, want.hit, got.frames_stored,
					want.frames_stored));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	frb_req_if req_ch ();
	frb_rsp_if rsp_ch ();

	frame_ring_buffer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	frame_ring_shadow shadow = new();
	int sent_words = 0;
	int settings_used = 0;
	bit send_burst = 1'b0;
	bit take_burst = 1'b0;
	int cycle_count = 0;
	setting_t plan [8];

	always #10 clk = ~clk;

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
			input logic [IDX_W-1:0] i, input logic [OFF_W-1:0] o);
		int gap;
		if (sent_words % 32 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= k;
		req_ch.push_byte   <= b;
		req_ch.frame_index <= i;
		req_ch.byte_offset <= o;
		do @(posedge clk); while (!req_ch.ready);
		shadow.take_word(k, b, i, o);
		sent_words++;
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (shadow.replies.size() != 0);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.set_reg(r, v);
	endtask

	task automatic apply_setting(input int cap, input int fb);
		hold_until_drained();
		repeat (4) @(posedge clk);
		apb_write(REG_CAPACITY, cap);
		apb_write(REG_FRAME_BYTES, fb);
		settings_used++;
	endtask

	task automatic random_word(input int push_pct);
		logic [KIND_W-1:0] k;
		logic [IDX_W-1:0]  i;
		logic [OFF_W-1:0]  o;
		int roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 249) == 0)
			k = KIND_CLEAR;
		else if (roll < push_pct)
			k = KIND_PUSH;
		else if (roll >= 98)
			k = KIND_UNUSED;
		else
			k = KIND_READ;
		if ($urandom_range(0, 4) == 0)
			i = IDX_W'($urandom_range(0, 63));
		else
			i = (shadow.count > 63) ? IDX_W'($urandom_range(0, 63))
				: IDX_W'($urandom_range(0, shadow.count));
		if ($urandom_range(0, 4) == 0)
			o = OFF_W'($urandom_range(0, 255));
		else
			o = OFF_W'($urandom_range(0, shadow.eff_fb() - 1));
		send_word(k, BYTE_W'($urandom_range(0, 255)), i, o);
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : response_side
		rsp_t got;
		int gap;
		int taken;
		taken = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 32 == 0)
				take_burst = ($urandom_range(0, 3) == 0);
			gap = take_burst ? 0 : $urandom_range(0, 7);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.read_byte     = rsp_ch.read_byte;
			got.hit           = rsp_ch.hit;
			got.frames_stored = rsp_ch.frames_stored;
			shadow.check_word(got);
			taken++;
		end
	end

	initial begin : request_side
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.kind        <= KIND_PUSH;
		req_ch.push_byte   <= '0;
		req_ch.frame_index <= '0;
		req_ch.byte_offset <= '0;
		plan = '{
			'{3, 4, 200, 55},
			'{0, 5, 60, 50},
			'{64, 1, 100, 60},
			'{2, 300, 450, 80},
			'{100, 0, 100, 55},
			'{64, 256, 80, 60},
			'{7, 3, 100, 50},
			'{2, 1, 100, 45}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: an empty store misses, and the unused code does nothing.
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);
		send_word(KIND_UNUSED, 8'hFF, 6'd63, 8'd255);

		apply_setting(2, 2);
		send_word(KIND_PUSH, 8'hAA, 6'd0, 8'd0);
		send_word(KIND_PUSH, 8'h55, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd1);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd2);
		send_word(KIND_READ, 8'h00, 6'd1, 8'd0);
		send_word(KIND_PUSH, 8'h00, 6'd0, 8'd0);
		send_word(KIND_PUSH, 8'hFF, 6'd0, 8'd0);
		// Store full with a frame half written: the oldest frame is gone.
		send_word(KIND_PUSH, 8'h3C, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd1, 8'd1);
		send_word(KIND_READ, 8'h00, 6'd63, 8'd255);
		send_word(KIND_PUSH, 8'hC3, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd1, 8'd1);
		send_word(KIND_UNUSED, 8'h81, 6'd42, 8'd129);
		send_word(KIND_CLEAR, 8'h7E, 6'd21, 8'd126);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);
		send_word(KIND_PUSH, 8'h7E, 6'd0, 8'd0);
		send_word(KIND_READ, 8'h00, 6'd0, 8'd0);

		foreach (plan[p]) begin
			apply_setting(plan[p].cap, plan[p].fb);
			for (int n = 0; n < plan[p].words; n++) begin
				if (n == 60)
					hold_until_drained();
				random_word(plan[p].push_pct);
			end
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		$display("Drove %0d request words over %0d register settings: %0d reads hit, %0d %s",
			sent_words, settings_used, shadow.hits, shadow.commits, "frames committed.");
		$display("Checked %0d response words, %0d mismatches.", shadow.checked, shadow.errors);
		if (shadow.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/frb_pkg.sv
rtl/frb_if.sv
rtl/frb_core.sv
rtl/frame_ring_buffer.sv
tb/testbench.sv
